### src/dpm_pkg.sv
package dpm_pkg;

    localparam int ADDR_W          = 32;
    localparam int IDX_W           = 10;
    localparam int OFFSET_W        = 12;
    localparam int PAGE_W          = ADDR_W - OFFSET_W;
    localparam int STATUS_W        = 3;
    localparam int DIR_ENTRIES     = 1 << IDX_W;
    localparam int POOL_TABLES_DEF = 16;

    localparam logic [ADDR_W-1:0] ENTRY_FLAGS = ADDR_W'(7);

    typedef enum logic [STATUS_W-1:0] {
        ST_MAPPED        = 3'd0,
        ST_NEW_TABLE     = 3'd1,
        ST_OUT_OF_TABLES = 3'd2,
        ST_OUT_OF_FRAMES = 3'd3,
        ST_BELOW_BOUND   = 3'd4,
        ST_HALTED        = 3'd5
    } dpm_status_t;

    typedef enum logic [1:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_UPDATE
    } dpm_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load;
        logic commit;
    } dpm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic result_full;
    } dpm_sts_t;

endpackage

### src/dpm_if.sv
interface dpm_fault_if;
    import dpm_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] fault_address;
    logic [ADDR_W-1:0] frame_address;

    modport source (output valid, output fault_address, output frame_address, input ready);
    modport sink   (input valid, input fault_address, input frame_address, output ready);
endinterface

interface dpm_result_if;
    import dpm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    directory_index;
    logic                directory_write;
    logic [ADDR_W-1:0]   directory_entry;
    logic                clear_table;
    logic [ADDR_W-1:0]   table_address;
    logic [IDX_W-1:0]    table_index;
    logic                page_write;
    logic [ADDR_W-1:0]   page_entry;
    logic [ADDR_W-1:0]   page_aligned_address;

    modport source (
        output valid, output status, output directory_index, output directory_write,
        output directory_entry, output clear_table, output table_address,
        output table_index, output page_write, output page_entry,
        output page_aligned_address, input ready
    );
    modport sink (
        input valid, input status, input directory_index, input directory_write,
        input directory_entry, input clear_table, input table_address,
        input table_index, input page_write, input page_entry,
        input page_aligned_address, output ready
    );
endinterface

interface dpm_cfg_if;
    import dpm_pkg::*;

    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] pool_base_page;

    modport source (output valid, output pool_base_page, input ready);
    modport sink   (input valid, input pool_base_page, output ready);
endinterface

### src/dpm_ram.sv
module dpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/dpm_ctrl.sv
module dpm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output dpm_pkg::dpm_cmd_t cmd,
    input  dpm_pkg::dpm_sts_t sts
);
    import dpm_pkg::*;

    dpm_state_t state_reg;
    dpm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.load       = 1'b0;
        cmd.commit     = 1'b0;
        case (state_reg)
            FSM_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = FSM_UPDATE;
                end
            end
            FSM_UPDATE:
            begin
                // hold until the result register can take the outcome
                if (!sts.result_full)
                begin
                    cmd.commit = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_CLEAR;
            end
        endcase
    end

endmodule

### src/dpm_datapath.sv
module dpm_datapath #(
    parameter int POOL_TABLES = dpm_pkg::POOL_TABLES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dpm_pkg::dpm_cmd_t            cmd,
    output dpm_pkg::dpm_sts_t            sts,
    input  logic                         cfg_write,
    input  logic [dpm_pkg::PAGE_W-1:0]   cfg_pool_base_page,
    input  logic [dpm_pkg::ADDR_W-1:0]   in_fault_address,
    input  logic [dpm_pkg::ADDR_W-1:0]   in_frame_address,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dpm_pkg::STATUS_W-1:0] out_status,
    output logic [dpm_pkg::IDX_W-1:0]    out_directory_index,
    output logic                         out_directory_write,
    output logic [dpm_pkg::ADDR_W-1:0]   out_directory_entry,
    output logic [dpm_pkg::ADDR_W-1:0]   out_table_address,
    output logic [dpm_pkg::IDX_W-1:0]    out_table_index,
    output logic                         out_page_write,
    output logic [dpm_pkg::ADDR_W-1:0]   out_page_entry,
    output logic [dpm_pkg::ADDR_W-1:0]   out_page_aligned_address
);
    import dpm_pkg::*;

    localparam int SLOT_W = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int USED_W = $clog2(POOL_TABLES + 1);
    localparam int WORD_W = SLOT_W + 1;

    // control state
    logic [PAGE_W-1:0] pool_base_reg;
    logic [USED_W-1:0] used_reg;
    logic              halted_reg;
    logic [IDX_W-1:0]  clr_cnt_reg;
    logic              out_valid_reg;

    // captured transaction
    logic [ADDR_W-1:0] fault_reg;
    logic [ADDR_W-1:0] frame_reg;

    // result register
    logic [STATUS_W-1:0] status_reg;
    logic                dwrite_reg;
    logic [ADDR_W-1:0]   dentry_reg;
    logic [ADDR_W-1:0]   taddr_reg;
    logic                pwrite_reg;
    logic [ADDR_W-1:0]   pentry_reg;
    logic [ADDR_W-1:0]   fault_out_reg;

    // directory store: {present, slot}
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    logic [IDX_W-1:0]    di;
    logic                present;
    logic                pool_empty;
    logic                alloc;
    logic                halt_now;
    logic [SLOT_W-1:0]   slot;
    logic [PAGE_W-1:0]   table_page;
    logic [ADDR_W-1:0]   table_addr;
    dpm_status_t         status_c;
    logic                dwrite_c;
    logic [ADDR_W-1:0]   dentry_c;
    logic [ADDR_W-1:0]   taddr_c;
    logic                pwrite_c;
    logic [ADDR_W-1:0]   pentry_c;

    assign di         = fault_reg[ADDR_W-1 -: IDX_W];
    assign present    = ram_rdata[SLOT_W];
    assign pool_empty = (used_reg >= USED_W'(POOL_TABLES));
    assign slot       = present ? ram_rdata[SLOT_W-1:0] : used_reg[SLOT_W-1:0];
    assign table_page = pool_base_reg + PAGE_W'(slot);
    assign table_addr = {table_page, {OFFSET_W{1'b0}}};

    always_comb
    begin
        status_c = ST_MAPPED;
        dwrite_c = 1'b0;
        dentry_c = '0;
        taddr_c  = '0;
        pwrite_c = 1'b0;
        pentry_c = '0;
        alloc    = 1'b0;
        halt_now = 1'b0;
        if (halted_reg)
        begin
            status_c = ST_HALTED;
        end
        else if (di == '0)
        begin
            status_c = ST_BELOW_BOUND;
            halt_now = 1'b1;
        end
        else if (!present && pool_empty)
        begin
            status_c = ST_OUT_OF_TABLES;
            halt_now = 1'b1;
        end
        else
        begin
            alloc   = !present;
            dwrite_c = !present;
            dentry_c = present ? '0 : (table_addr | ENTRY_FLAGS);
            taddr_c  = table_addr;
            if (frame_reg == '0)
            begin
                status_c = ST_OUT_OF_FRAMES;
                halt_now = 1'b1;
            end
            else
            begin
                pwrite_c = 1'b1;
                pentry_c = frame_reg | ENTRY_FLAGS;
                status_c = present ? ST_MAPPED : ST_NEW_TABLE;
            end
        end
    end

    // clearing sweep writes zero; a fresh table writes its slot as present
    assign ram_we    = cmd.clear_step || (cmd.commit && alloc);
    assign ram_waddr = cmd.clear_step ? clr_cnt_reg : di;
    assign ram_wdata = cmd.clear_step ? '0 : {1'b1, used_reg[SLOT_W-1:0]};

    dpm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DIR_ENTRIES)
    ) u_dir_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.load),
        .raddr (in_fault_address[ADDR_W-1 -: IDX_W]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
            used_reg      <= '0;
            halted_reg    <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                pool_base_reg <= cfg_pool_base_page;
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                if (alloc)
                begin
                    used_reg <= used_reg + 1'b1;
                end
                if (halt_now)
                begin
                    halted_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fault_reg <= in_fault_address;
            frame_reg <= in_frame_address;
        end
        if (cmd.commit)
        begin
            status_reg    <= status_c;
            dwrite_reg    <= dwrite_c;
            dentry_reg    <= dentry_c;
            taddr_reg     <= taddr_c;
            pwrite_reg    <= pwrite_c;
            pentry_reg    <= pentry_c;
            fault_out_reg <= fault_reg;
        end
    end

    assign sts.clear_last  = (clr_cnt_reg == '1);
    assign sts.result_full = out_valid_reg && !out_ready;

    assign out_valid                = out_valid_reg;
    assign out_status               = status_reg;
    assign out_directory_index      = fault_out_reg[ADDR_W-1 -: IDX_W];
    assign out_directory_write      = dwrite_reg;
    assign out_directory_entry      = dentry_reg;
    assign out_table_address        = taddr_reg;
    assign out_table_index          = fault_out_reg[OFFSET_W +: IDX_W];
    assign out_page_write           = pwrite_reg;
    assign out_page_entry           = pentry_reg;
    assign out_page_aligned_address = {fault_out_reg[ADDR_W-1:OFFSET_W], {OFFSET_W{1'b0}}};

endmodule

### src/demand_page_mapper_core.sv
// demand page mapper: takes one faulting virtual address and one offered
// physical frame per fault transaction and returns one result transaction
// describing the directory and page table writes for two-level paging.
// after reset the block sweeps its 1024-entry directory store, one entry a
// cycle, and takes no fault until that sweep has finished (configuration
// writes are taken throughout). after that each fault is first captured
// while the directory store is read, then decided and written back
// through the single read-modify-write of that store. the result sits in an
// output register, so the next fault is taken while a result waits. a refused
// address, an empty table pool or a missing frame makes the block halt: every
// later fault reports halted until reset. pool_base_page may be written only
// while no fault is in flight.
module demand_page_mapper_core #(
    parameter int POOL_TABLES = dpm_pkg::POOL_TABLES_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    dpm_fault_if.sink    fault,
    dpm_result_if.source result,
    dpm_cfg_if.sink      cfg
);
    import dpm_pkg::*;

    // command and status between sequencer and datapath
    dpm_cmd_t cmd;
    dpm_sts_t sts;

    // the configuration register is always writable
    assign cfg.ready = 1'b1;

    // the result register carries both flags of a new table together
    assign result.clear_table = result.directory_write;

    // sequencer: clearing sweep, capture, decide
    dpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fault.valid),
        .in_ready (fault.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath: directory store, pool counter, halt flag and result register
    dpm_datapath #(
        .POOL_TABLES (POOL_TABLES)
    ) u_datapath (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .cmd                      (cmd),
        .sts                      (sts),
        .cfg_write                (cfg.valid),
        .cfg_pool_base_page       (cfg.pool_base_page),
        .in_fault_address         (fault.fault_address),
        .in_frame_address         (fault.frame_address),
        .out_valid                (result.valid),
        .out_ready                (result.ready),
        .out_status               (result.status),
        .out_directory_index      (result.directory_index),
        .out_directory_write      (result.directory_write),
        .out_directory_entry      (result.directory_entry),
        .out_table_address        (result.table_address),
        .out_table_index          (result.table_index),
        .out_page_write           (result.page_write),
        .out_page_entry           (result.page_entry),
        .out_page_aligned_address (result.page_aligned_address)
    );

endmodule

### src/dpm_checker.sv
module dpm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [dpm_pkg::STATUS_W-1:0] status,
    input logic                         directory_write,
    input logic                         clear_table,
    input logic                         page_write
);
    import dpm_pkg::*;

    logic halted_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_seen_reg <= 1'b0;
        end
        else if (out_valid && out_ready &&
                 (status inside {ST_OUT_OF_TABLES, ST_OUT_OF_FRAMES, ST_BELOW_BOUND}))
        begin
            halted_seen_reg <= 1'b1;
        end
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before being taken");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_seen_reg && out_valid |-> status == ST_HALTED)
        else $error("result after a halting fault is not halted");

    a_dir_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && directory_write |->
            clear_table && (status == ST_NEW_TABLE || status == ST_OUT_OF_FRAMES))
        else $error("directory write with inconsistent status");

    a_page_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> page_write == (status == ST_MAPPED || status == ST_NEW_TABLE))
        else $error("page write does not match status");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second fault taken while one is in flight");

endmodule

bind demand_page_mapper_core dpm_checker u_dpm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (fault.valid),
    .in_ready        (fault.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .status          (result.status),
    .directory_write (result.directory_write),
    .clear_table     (result.clear_table),
    .page_write      (result.page_write)
);

### tb/demand_page_mapper_core_test.sv
module demand_page_mapper_core_test;
    import dpm_pkg::*;

    localparam int POOL_TABLES   = POOL_TABLES_DEF;
    localparam int ITEMS_PER_RUN = 190;     // random fault transactions per pool setting
    localparam int HOLD_OFF      = 300;     // length of the one long result-side hold-off
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 100000;  // clearing sweep plus stalls, several times over

    // the way the run is brought to a halt; the halt is sticky and reset comes only once,
    // so each run ends in exactly one of these
    typedef enum int {
        HALT_BELOW_BOUND,
        HALT_NO_TABLE,
        HALT_NO_FRAME,
        HALT_NO_FRAME_FRESH
    } halt_cause_t;

    // one result transaction, field for field
    typedef struct packed {
        dpm_status_t       status;
        logic [IDX_W-1:0]  directory_index;
        logic              directory_write;
        logic [ADDR_W-1:0] directory_entry;
        logic              clear_table;
        logic [ADDR_W-1:0] table_address;
        logic [IDX_W-1:0]  table_index;
        logic              page_write;
        logic [ADDR_W-1:0] page_entry;
        logic [ADDR_W-1:0] page_aligned_address;
    } mapping_result_t;

    // mirror of the directory and the table pool, plus the mappings still owed
    class page_map_scoreboard;
        mapping_result_t   pending_mappings[$];
        logic [PAGE_W-1:0] pool_base;
        bit                dir_present [DIR_ENTRIES];
        int unsigned       dir_slot [DIR_ENTRIES];
        int unsigned       tables_taken;
        bit                halted;
        int unsigned       failures;

        function new();
            pool_base       = '0;
            tables_taken    = 0;
            halted          = 1'b0;
            failures        = 0;
            dir_present[0]  = 1'b1;
        endfunction

        // pool slot k sits at (pool_base + k) pages, wrapping at 4 GB
        function logic [ADDR_W-1:0] table_base(int unsigned slot);
            logic [ADDR_W-1:0] page;
            page = ADDR_W'(pool_base) + ADDR_W'(slot);
            return page << OFFSET_W;
        endfunction

        function void note_fault(logic [ADDR_W-1:0] va, logic [ADDR_W-1:0] frame);
            mapping_result_t  m;
            logic [IDX_W-1:0] di;
            bit               fresh;
            m     = '0;
            fresh = 1'b0;
            di    = va[ADDR_W-1 -: IDX_W];
            m.directory_index      = di;
            m.table_index          = va[OFFSET_W +: IDX_W];
            m.page_aligned_address = {va[ADDR_W-1:OFFSET_W], {OFFSET_W{1'b0}}};
            if (halted)
                m.status = ST_HALTED;
            else if (di == '0)
            begin
                m.status = ST_BELOW_BOUND;
                halted   = 1'b1;
            end
            else if (!dir_present[di] && tables_taken >= POOL_TABLES)
            begin
                m.status = ST_OUT_OF_TABLES;
                halted   = 1'b1;
            end
            else
            begin
                if (!dir_present[di])
                begin
                    dir_slot[di]      = tables_taken;
                    dir_present[di]   = 1'b1;
                    tables_taken++;
                    fresh             = 1'b1;
                    m.directory_write = 1'b1;
                    m.clear_table     = 1'b1;
                    m.directory_entry = table_base(dir_slot[di]) | ENTRY_FLAGS;
                end
                // directory is updated before the frame is looked at
                m.table_address = table_base(dir_slot[di]);
                if (frame == '0)
                begin
                    m.status = ST_OUT_OF_FRAMES;
                    halted   = 1'b1;
                end
                else
                begin
                    m.page_write = 1'b1;
                    m.page_entry = frame | ENTRY_FLAGS;
                    m.status     = fresh ? ST_NEW_TABLE : ST_MAPPED;
                end
            end
            pending_mappings.push_back(m);
        endfunction

        function void compare_field(string name, logic [ADDR_W-1:0] want,
                                    logic [ADDR_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(mapping_result_t got);
            mapping_result_t want;
            if (pending_mappings.size() == 0)
            begin
                $error("result transaction with no fault outstanding");
                failures++;
                return;
            end
            want = pending_mappings.pop_front();
            compare_field("status", ADDR_W'(want.status), ADDR_W'(got.status));
            compare_field("directory_index", ADDR_W'(want.directory_index),
                          ADDR_W'(got.directory_index));
            compare_field("directory_write", ADDR_W'(want.directory_write),
                          ADDR_W'(got.directory_write));
            compare_field("directory_entry", want.directory_entry, got.directory_entry);
            compare_field("clear_table", ADDR_W'(want.clear_table), ADDR_W'(got.clear_table));
            compare_field("table_address", want.table_address, got.table_address);
            compare_field("table_index", ADDR_W'(want.table_index), ADDR_W'(got.table_index));
            compare_field("page_write", ADDR_W'(want.page_write), ADDR_W'(got.page_write));
            compare_field("page_entry", want.page_entry, got.page_entry);
            compare_field("page_aligned_address", want.page_aligned_address,
                          got.page_aligned_address);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dpm_fault_if  fault_ch ();
    dpm_result_if result_ch ();
    dpm_cfg_if    cfg_ch ();

    demand_page_mapper_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .fault  (fault_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    page_map_scoreboard sb;

    // stimulus bookkeeping: which directory entries have been handed a table
    bit               dir_claimed [DIR_ENTRIES];
    logic [IDX_W-1:0] mapped_dirs[$];
    int unsigned      table_budget;

    // shared knobs for both sides of the handshake
    bit          quiet_stretch = 1'b0;  // no idling on either side
    bit          hold_off_req  = 1'b0;  // result side takes the one long hold-off when set
    int unsigned cycle_count   = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // random directory entry that has no table yet (never entry 0)
    function logic [IDX_W-1:0] unclaimed_dir();
        logic [IDX_W-1:0] d;
        do
            d = IDX_W'($urandom_range(1, DIR_ENTRIES - 1));
        while (dir_claimed[d]);
        return d;
    endfunction

    function logic [ADDR_W-1:0] random_va(logic [IDX_W-1:0] d);
        return {d, (IDX_W + OFFSET_W)'($urandom)};
    endfunction

    // any frame but the "none available" one
    function logic [ADDR_W-1:0] random_frame();
        logic [ADDR_W-1:0] f;
        f = $urandom;
        if (f == '0)
            f = ADDR_W'(1);
        return f;
    endfunction

    // one fault transaction, with a random idle gap in front of it now and then
    task offer_fault(input logic [ADDR_W-1:0] va, input logic [ADDR_W-1:0] frame);
        logic [IDX_W-1:0] d;
        d = va[ADDR_W-1 -: IDX_W];
        if (!quiet_stretch && $urandom_range(0, 99) < 19)
        begin
            fault_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        fault_ch.valid         <= 1'b1;
        fault_ch.fault_address <= va;
        fault_ch.frame_address <= frame;
        do
            @(posedge clk);
        while (fault_ch.ready !== 1'b1);
        sb.note_fault(va, frame);
        if (d != '0 && !dir_claimed[d])
        begin
            dir_claimed[d] = 1'b1;
            mapped_dirs.push_back(d);
        end
    endtask

    // mostly faults on entries that already hold a table, now and then a fresh one
    task map_random(input int count);
        logic [IDX_W-1:0] d;
        repeat (count)
        begin
            if (mapped_dirs.size() < table_budget && $urandom_range(0, 49) == 0)
                d = unclaimed_dir();
            else
                d = mapped_dirs[$urandom_range(0, mapped_dirs.size() - 1)];
            offer_fault(random_va(d), random_frame());
        end
    endtask

    // wait for every owed result; nothing is left in flight afterwards
    task drain();
        fault_ch.valid <= 1'b0;
        while (sb.pending_mappings.size() != 0)
            @(posedge clk);
    endtask

    task write_pool_base(input logic [PAGE_W-1:0] page);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.pool_base_page <= page;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        sb.pool_base = page;
    endtask

    // use up the table budget, then trip the chosen halt and keep faulting into it
    task end_in_halt(input halt_cause_t cause);
        while (mapped_dirs.size() < table_budget)
            offer_fault(random_va(unclaimed_dir()), random_frame());
        case (cause)
            HALT_BELOW_BOUND:
                offer_fault(random_va('0), random_frame());
            HALT_NO_TABLE:
                offer_fault(random_va(unclaimed_dir()), random_frame());
            HALT_NO_FRAME:
                offer_fault(random_va(mapped_dirs[$urandom_range(0, mapped_dirs.size() - 1)]),
                            '0);
            default:
                offer_fault(random_va(unclaimed_dir()), '0);
        endcase
        // halted: every later fault reports halted, whatever it carries
        repeat (12)
            offer_fault(random_va(IDX_W'($urandom)), $urandom_range(0, 1) ? random_frame() : '0);
    endtask

    // result side: random back-pressure, a calm stretch, and one long hold-off
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
                result_ch.ready <= quiet_stretch || ($urandom_range(0, 99) >= 19);
        end
    end

    // every accepted result transaction goes to the scoreboard
    always @(posedge clk)
    begin : result_monitor
        mapping_result_t seen;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            seen.status               = dpm_status_t'(result_ch.status);
            seen.directory_index      = result_ch.directory_index;
            seen.directory_write      = result_ch.directory_write;
            seen.directory_entry      = result_ch.directory_entry;
            seen.clear_table          = result_ch.clear_table;
            seen.table_address        = result_ch.table_address;
            seen.table_index          = result_ch.table_index;
            seen.page_write           = result_ch.page_write;
            seen.page_entry           = result_ch.page_entry;
            seen.page_aligned_address = result_ch.page_aligned_address;
            sb.check_result(seen);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("demand_page_mapper_core verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [PAGE_W-1:0] pool_settings [5];
        logic [ADDR_W-1:0] directed_va [7];
        logic [ADDR_W-1:0] directed_frame [7];
        halt_cause_t       halt_cause;

        sb = new();
        rst_n                  = 1'b0;
        fault_ch.valid         = 1'b0;
        fault_ch.fault_address = '0;
        fault_ch.frame_address = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.pool_base_page  = '0;

        // the fresh-table out-of-frames case needs one pool table left over
        halt_cause   = halt_cause_t'($urandom_range(0, 3));
        table_budget = (halt_cause == HALT_NO_FRAME_FRESH) ? POOL_TABLES - 1 : POOL_TABLES;

        // pool at page 0, at the very top, straddling the 4 GB wrap, then anywhere
        pool_settings = '{20'h00000, 20'hFFFFF, 20'hFFFF8, PAGE_W'($urandom),
                          PAGE_W'($urandom)};

        // directed: all-ones and sparse directory/table indexes, extreme frames,
        // new table then reuse, frame with the flag bits already set
        directed_va    = '{{10'h3FF, 10'h3FF, 12'hFFF}, {10'h3FF, 10'h000, 12'h000},
                           {10'h200, 10'h155, 12'h800}, {10'h001, 10'h2AA, 12'h7FF},
                           {10'h200, 10'h3FF, 12'h001}, {10'h001, 10'h200, 12'hABC},
                           {10'h3FF, 10'h001, 12'h000}};
        directed_frame = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_F000,
                           32'h0000_0007, 32'h1234_5006, 32'hFFFF_F000};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // one phase per pool setting; no fault is in flight at each register write
        for (int p = 0; p < 5; p++)
        begin
            write_pool_base(pool_settings[p]);
            quiet_stretch = (p == 1);
            hold_off_req  = (p == 2);
            if (p == 0)
                foreach (directed_va[i])
                    offer_fault(directed_va[i], directed_frame[i]);
            map_random(ITEMS_PER_RUN);
            drain();
        end
        quiet_stretch = 1'b0;

        end_in_halt(halt_cause);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.failures == 0)
            $display("demand_page_mapper_core verification clean");
        else
            $display("demand_page_mapper_core verification failed");
        $finish;
    end

endmodule
